/* rtl/core/nrgf_pkg.sv */
// Package for the NMEA RMC/GGA field extractor.
// Holds the result word type, the tracker phase type, the header constants and the header match step.
// No dependencies.
`default_nettype none

package nrgf_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_EXTRACT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [3:0] id;
    logic [7:0] ch;
    logic       ok;
  } item_t;

  typedef struct packed {
    logic [2:0] pos;
    logic       hit;
  } match_t;

  localparam logic [47:0] RMC_HDR    = 48'h24_47_50_52_4D_43; // "$GPRMC"
  localparam logic [47:0] GGA_HDR    = 48'h24_47_50_47_47_41; // "$GPGGA"
  localparam logic [7:0]  CH_DOLLAR  = 8'h24;
  localparam logic [7:0]  CH_COMMA   = 8'h2C;
  localparam logic [2:0]  HDR_LAST   = 3'd5;
  localparam logic [3:0]  RMC_FIELDS = 4'd11;
  localparam logic [3:0]  GGA_SKIP   = 4'd7;
  localparam logic [3:0]  ID_RMC_MODE = 4'd11;
  localparam logic [3:0]  ID_GGA_SATS = 4'd12;
  localparam logic [3:0]  ID_GGA_HDOP = 4'd13;
  localparam logic [15:0] MIN_LENGTH_RESET = 16'd100;

  // One step of a header matcher; positions past the header wrap as modulo six.
  function automatic match_t match_step(input logic [2:0] pos, input logic [47:0] hdr,
                                        input logic [7:0] b);
    match_t     r;
    logic [2:0] p;
    logic [7:0] c;
    p = (pos > HDR_LAST) ? pos - 3'd6 : pos;
    case (p)
      3'd0:    c = hdr[47:40];
      3'd1:    c = hdr[39:32];
      3'd2:    c = hdr[31:24];
      3'd3:    c = hdr[23:16];
      3'd4:    c = hdr[15:8];
      default: c = hdr[7:0];
    endcase
    r.hit = 1'b0;
    if (b == c) begin
      if (p == HDR_LAST) begin
        r.pos = 3'd0;
        r.hit = 1'b1;
      end else begin
        r.pos = p + 3'd1;
      end
    end else begin
      r.pos = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/nrgf_rmc_track.sv */
// RMC tracker: finds the first $GPRMC header and streams its eleven fields and mode character.
// Depends on nrgf_pkg.
`default_nettype none

module nrgf_rmc_track (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic [7:0]      b,
  input  wire logic            last,
  output nrgf_pkg::item_t      item,
  output logic                 done
);

  logic [2:0]       match_pos, match_pos_next;
  nrgf_pkg::phase_t phase, phase_next;
  logic [3:0]       comma_count, comma_count_next;
  nrgf_pkg::match_t ms;

  always_comb begin
    ms               = nrgf_pkg::match_step(match_pos, nrgf_pkg::RMC_HDR, b);
    match_pos_next   = match_pos;
    phase_next       = phase;
    comma_count_next = comma_count;
    unique case (phase)
      nrgf_pkg::PH_SEARCH: begin
        match_pos_next = ms.pos;
        if (ms.hit) begin
          phase_next       = nrgf_pkg::PH_EXTRACT;
          comma_count_next = 4'd0;
        end
      end
      nrgf_pkg::PH_EXTRACT: begin
        if (comma_count == 4'd0) begin
          if (b == nrgf_pkg::CH_COMMA) comma_count_next = 4'd1;
        end else if (comma_count <= nrgf_pkg::RMC_FIELDS) begin
          if (b == nrgf_pkg::CH_COMMA) comma_count_next = comma_count + 4'd1;
        end else begin
          phase_next = nrgf_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item      = '0;
    item.kind = nrgf_pkg::KIND_CHAR;
    if (phase == nrgf_pkg::PH_EXTRACT && comma_count != 4'd0) begin
      item.vld = 1'b1;
      if (comma_count <= nrgf_pkg::RMC_FIELDS) begin
        item.id = comma_count - 4'd1;
        if (b == nrgf_pkg::CH_COMMA) begin
          item.kind = nrgf_pkg::KIND_END;
        end else begin
          item.ch = b;
        end
      end else begin
        // mode character: any byte, no end marker
        item.id = nrgf_pkg::ID_RMC_MODE;
        item.ch = b;
      end
    end
  end

  assign done = (phase_next == nrgf_pkg::PH_DONE);

  always_ff @(posedge clk) begin
    if (rst || (adv && last)) begin
      match_pos   <= 3'd0;
      phase       <= nrgf_pkg::PH_SEARCH;
      comma_count <= 4'd0;
    end else if (adv) begin
      match_pos   <= match_pos_next;
      phase       <= phase_next;
      comma_count <= comma_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nrgf_gga_track.sv */
// GGA tracker: finds the first $GPGGA header, skips seven commas, streams satellites and HDOP.
// Depends on nrgf_pkg.
`default_nettype none

module nrgf_gga_track (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic [7:0]      b,
  input  wire logic            last,
  output nrgf_pkg::item_t      item,
  output logic                 done
);

  logic [2:0]       match_pos, match_pos_next;
  nrgf_pkg::phase_t phase, phase_next;
  logic [3:0]       comma_count, comma_count_next;
  nrgf_pkg::match_t ms;
  logic [3:0]       id;

  assign id = (comma_count == nrgf_pkg::GGA_SKIP) ? nrgf_pkg::ID_GGA_SATS
                                                  : nrgf_pkg::ID_GGA_HDOP;

  always_comb begin
    ms               = nrgf_pkg::match_step(match_pos, nrgf_pkg::GGA_HDR, b);
    match_pos_next   = match_pos;
    phase_next       = phase;
    comma_count_next = comma_count;
    unique case (phase)
      nrgf_pkg::PH_SEARCH: begin
        match_pos_next = ms.pos;
        if (ms.hit) begin
          phase_next       = nrgf_pkg::PH_EXTRACT;
          comma_count_next = 4'd0;
        end
      end
      nrgf_pkg::PH_EXTRACT: begin
        if (b == nrgf_pkg::CH_COMMA) begin
          if (comma_count >= nrgf_pkg::GGA_SKIP && id == nrgf_pkg::ID_GGA_HDOP) begin
            phase_next = nrgf_pkg::PH_DONE;
          end else begin
            comma_count_next = comma_count + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item      = '0;
    item.kind = nrgf_pkg::KIND_CHAR;
    if (phase == nrgf_pkg::PH_EXTRACT && comma_count >= nrgf_pkg::GGA_SKIP) begin
      item.vld = 1'b1;
      item.id  = id;
      if (b == nrgf_pkg::CH_COMMA) begin
        item.kind = nrgf_pkg::KIND_END;
      end else begin
        item.ch = b;
      end
    end
  end

  assign done = (phase_next == nrgf_pkg::PH_DONE);

  always_ff @(posedge clk) begin
    if (rst || (adv && last)) begin
      match_pos   <= 3'd0;
      phase       <= nrgf_pkg::PH_SEARCH;
      comma_count <= 4'd0;
    end else if (adv) begin
      match_pos   <= match_pos_next;
      phase       <= phase_next;
      comma_count <= comma_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nrgf_result_buf.sv */
// Result register: holds the up to three words one byte causes and hands them out in order.
// Depends on nrgf_pkg.
`default_nettype none

module nrgf_result_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire nrgf_pkg::item_t rmc_item,
  input  wire nrgf_pkg::item_t gga_item,
  input  wire nrgf_pkg::item_t stat_item,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nrgf_pkg::item_t      head,
  output logic                 head_last
);

  logic [2:0]      mask, mask_next;
  logic [2:0]      sel;
  nrgf_pkg::item_t slot [3];

  always_comb begin
    if (mask[0])      sel = 3'b001;
    else if (mask[1]) sel = 3'b010;
    else              sel = 3'b100;
    if (mask[0])      head = slot[0];
    else if (mask[1]) head = slot[1];
    else              head = slot[2];
  end

  assign out_valid = |mask;
  assign head_last = ((mask & ~sel) == 3'b000);
  assign can_load  = !out_valid || (head_last && out_ready);

  always_comb begin
    mask_next = mask;
    if (out_valid && out_ready) mask_next = mask & ~sel;
    if (load) mask_next = {stat_item.vld, gga_item.vld, rmc_item.vld};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 3'b000;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= rmc_item;
      slot[1] <= gga_item;
      slot[2] <= stat_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nmea_rmc_gga_field_extractor.sv */
// NMEA RMC/GGA field extractor, top level: input register, trackers, byte count, result register.
// A byte passes the input register and then the result register before its first word is offered.
// Throughput: one byte per cycle while each byte causes at most one word and out_ready is high;
// a byte causing more words holds the input until they leave the one-word-per-cycle result port.
// Reset (rst, synchronous): trackers searching, byte count zero, min_length back to 100.
// Depends on nrgf_pkg, nrgf_rmc_track, nrgf_gga_track, nrgf_result_buf.
`default_nettype none

module nmea_rmc_gga_field_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       item_kind,
  output logic [3:0]       field_id,
  output logic [7:0]       field_char,
  output logic             sentence_valid,
  output logic             last_result
);

  logic [15:0]     min_length;
  logic            in_q_valid;
  logic [7:0]      in_q_byte;
  logic            in_q_last;
  logic            adv;
  logic            can_load;
  logic [15:0]     byte_count, byte_count_next;
  logic            rmc_done, gga_done;
  nrgf_pkg::item_t rmc_item, gga_item, stat_item, head;
  logic            head_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= nrgf_pkg::MIN_LENGTH_RESET;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  // input register frees a slot while a result word is still waiting
  assign adv      = in_q_valid && can_load;
  assign in_ready = !in_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
      in_q_last <= last_byte;
    end
  end

  // saturate at all ones
  assign byte_count_next = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst || (adv && in_q_last)) begin
      byte_count <= 16'd0;
    end else if (adv) begin
      byte_count <= byte_count_next;
    end
  end

  nrgf_rmc_track u_rmc (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .b    (in_q_byte),
    .last (in_q_last),
    .item (rmc_item),
    .done (rmc_done)
  );

  nrgf_gga_track u_gga (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .b    (in_q_byte),
    .last (in_q_last),
    .item (gga_item),
    .done (gga_done)
  );

  always_comb begin
    stat_item      = '0;
    stat_item.vld  = in_q_last;
    stat_item.kind = nrgf_pkg::KIND_STATUS;
    stat_item.ok   = (byte_count_next >= min_length) && rmc_done && gga_done;
  end

  nrgf_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .rmc_item  (rmc_item),
    .gga_item  (gga_item),
    .stat_item (stat_item),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .head_last (head_last)
  );

  assign item_kind      = head.kind;
  assign field_id       = head.id;
  assign field_char     = head.ch;
  assign sentence_valid = head.ok;
  assign last_result    = head_last;

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == nrgf_pkg::KIND_STATUS |-> last_result)
    else $error("status word is not the final word of its byte");

  a_valid_only_in_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && sentence_valid |-> item_kind == nrgf_pkg::KIND_STATUS)
    else $error("sentence_valid set outside a status word");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_q_valid && !can_load)
    else $error("input stalled with an empty input register");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    adv && in_q_last |=> byte_count == 16'd0)
    else $error("byte count not cleared after final byte");

endmodule

`default_nettype wire
